// ===== rtl/wscv_pkg.sv =====
package wscv_pkg;

  localparam int HDR_LEN = 131;
  localparam int VER_LEN = 14;

  // Version prefix of the first line, spelled out as byte codes.
  localparam logic [VER_LEN*8-1:0] VER_TEXT =
    {8'h57, 8'h69, 8'h67, 8'h6c, 8'h65, 8'h57, 8'h69,
     8'h66, 8'h69, 8'h2d, 8'h31, 8'h2e, 8'h36, 8'h2c};
  localparam logic [HDR_LEN*8-1:0] HDR_TEXT =
    {"MAC,SSID,AuthMode,FirstSeen,Channel,Frequency,RSSI,",
     "CurrentLatitude,CurrentLongitude,AltitudeMeters,AccuracyMeters,RCOIs,MfgrId,Type"};
  localparam logic [31:0] TYPE_TEXT = "WIFI";

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_END  = 1'b1;

  // Number parser phases.
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_SIGN  = 3'd1;
  localparam logic [2:0] PH_WHOLE = 3'd2;
  localparam logic [2:0] PH_DOT   = 3'd3;
  localparam logic [2:0] PH_FRAC  = 3'd4;

  // Header stages.
  localparam logic [1:0] HS_VER  = 2'd0;
  localparam logic [1:0] HS_COLS = 2'd1;
  localparam logic [1:0] HS_DATA = 2'd2;

  // Column numbers with rules.
  localparam logic [3:0] COL_MAC  = 4'd0;
  localparam logic [3:0] COL_TIME = 4'd3;
  localparam logic [3:0] COL_LAT  = 4'd7;
  localparam logic [3:0] COL_LON  = 4'd8;
  localparam logic [3:0] COL_TYPE = 4'd13;
  localparam logic [3:0] COL_NUM  = 4'd14;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

endpackage

// ===== rtl/wifi_scan_csv_validator_unit.sv =====
// Scan-log CSV validator: one byte or end marker per item, one result item each.
// The result item appears in the cycle after its input item is accepted.
// Throughput: one item every cycle unless out_ready holds off a full output; the
// whole check is one state update between input handshake and output register.
// Reset (rst_n low, synchronous) returns all parser state to the start of file,
// clears the row count and the error flag, and empties the output register.
module wifi_scan_csv_validator_unit #(
  parameter int CELL_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [31:0] out_row_count
);
  import wscv_pkg::*;

  // Cell length counter holds values up to CELL_BYTES-1.
  localparam int LW = $clog2(CELL_BYTES);
  localparam logic [LW-1:0] LEN_MAX = LW'(CELL_BYTES - 1);

  // Parser state.
  logic [1:0]    hstage_r, hstage_nxt;
  logic [LW-1:0] clen_r, clen_nxt;
  logic          hmatch_r, hmatch_nxt;
  logic          hmatch_cr_r, hmatch_cr_nxt;
  logic          last_cr_r, last_cr_nxt;
  logic          inq_r, inq_nxt;
  logic          qclosed_r, qclosed_nxt;
  logic          pcr_r, pcr_nxt;
  logic [3:0]    col_r, col_nxt;
  logic          cok_r, cok_nxt;
  logic [9:0]    whole_r, whole_nxt;
  logic [2:0]    phase_r, phase_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic          fnz_r, fnz_nxt;
  logic [31:0]   rows_r, rows_nxt;
  logic          err_r, err_nxt;

  logic          ovalid_r;
  logic          ook_r, ook_nxt;
  logic [31:0]   orows_r;

  logic          take;

  // The output register is the only buffer; it refills in the cycle it drains.
  assign in_ready = !ovalid_r || out_ready;
  assign take     = in_valid && in_ready;

  assign out_valid     = ovalid_r;
  assign out_ok        = ook_r;
  assign out_row_count = orows_r;

  always_comb begin
    logic [7:0]    ch;
    logic          fail;
    logic          do_app;
    logic          do_end;
    logic          row_end;
    logic          good;
    logic          feed;
    logic          dig;
    logic [3:0]    d;
    logic [LW-1:0] len;
    logic          m;
    logic          cfin;
    logic [9:0]    lim;
    logic          mac_sep;
    logic [13:0]   wmul;

    hstage_nxt    = hstage_r;
    clen_nxt      = clen_r;
    hmatch_nxt    = hmatch_r;
    hmatch_cr_nxt = hmatch_cr_r;
    last_cr_nxt   = last_cr_r;
    inq_nxt       = inq_r;
    qclosed_nxt   = qclosed_r;
    pcr_nxt       = pcr_r;
    col_nxt       = col_r;
    cok_nxt       = cok_r;
    whole_nxt     = whole_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    fnz_nxt       = fnz_r;
    rows_nxt      = rows_r;
    err_nxt       = err_r;
    ook_nxt       = 1'b0;

    fail    = 1'b0;
    do_app  = 1'b0;
    do_end  = 1'b0;
    row_end = 1'b0;
    good    = 1'b1;
    feed    = 1'b0;
    len     = clen_r;
    m       = hmatch_r;
    cfin    = 1'b0;
    lim     = 10'd0;
    mac_sep = 1'b0;
    wmul    = 14'd0;

    // An end marker feeds an LF when a row is still open.
    if (in_req_type == REQ_END) begin
      ch = CH_LF;
      if (!err_r && hstage_r == HS_DATA && !inq_r) begin
        feed = (clen_r != '0) || (col_r != COL_MAC) || qclosed_r || pcr_r;
      end
    end else begin
      ch   = in_byte_value;
      feed = !err_r;
    end
    dig = is_digit(ch);
    d   = dig ? 4'(ch - "0") : 4'd0;

    // Byte-level decision: reject, store into the cell, or close a cell.
    if (ch == CH_NUL) begin
      fail = 1'b1;
    end else if (hstage_r != HS_DATA) begin
      if (ch == CH_LF) begin
        if (last_cr_r) begin
          len = clen_r - 1'b1;
          if (hstage_r == HS_COLS) begin
            m = hmatch_cr_r;
          end
        end
        if (hstage_r == HS_VER) begin
          fail = !(m && len >= LW'(VER_LEN));
        end else begin
          fail = !(m && len == LW'(HDR_LEN));
        end
      end else begin
        do_app = 1'b1;
      end
    end else if (inq_r) begin
      if (ch != CH_QUOTE) begin
        do_app = 1'b1;
      end
    end else if (pcr_r && ch != CH_LF) begin
      fail = 1'b1;
    end else if (ch == CH_CR) begin
      fail = 1'b0;
    end else if (ch == CH_COMMA || ch == CH_LF) begin
      do_end  = 1'b1;
      row_end = (ch == CH_LF);
    end else if (ch == CH_QUOTE) begin
      if (qclosed_r) begin
        do_app = 1'b1;
      end else if (clen_r != '0) begin
        fail = 1'b1;
      end
    end else if (qclosed_r) begin
      fail = 1'b1;
    end else begin
      do_app = 1'b1;
    end

    if (do_app && clen_r >= LEN_MAX) begin
      fail = 1'b1;
    end

    // Cell close: per-column final check, then column advance.
    if (col_r == COL_LAT) begin
      lim = 10'd90;
    end else begin
      lim = 10'd180;
    end
    cfin = cok_r && (phase_r == PH_WHOLE || phase_r == PH_FRAC) &&
           (whole_r < lim || (whole_r == lim && !fnz_r));
    case (col_r)
      COL_MAC:  good = cok_r && clen_r == LW'(17);
      COL_TIME: good = cok_r && clen_r == LW'(19);
      COL_LAT:  good = cfin;
      COL_LON:  good = cfin;
      COL_TYPE: good = cok_r && clen_r == LW'(4);
      default:  good = 1'b1;
    endcase
    if (do_end) begin
      if (!good) begin
        fail = 1'b1;
      end else if (row_end && col_r != COL_TYPE) begin
        fail = 1'b1;
      end else if (!row_end && col_r + 4'd1 >= COL_NUM) begin
        fail = 1'b1;
      end
    end

    if (take && feed) begin
      if (fail) begin
        err_nxt = 1'b1;
        // Partial state changes before a failure are harmless: state is
        // frozen afterwards, except the end-cell column advance.
        if (do_end && good && !row_end) begin
          col_nxt = col_r + 4'd1;
        end
      end else if (hstage_r != HS_DATA && ch == CH_LF) begin
        hstage_nxt    = hstage_r + 2'd1;
        clen_nxt      = '0;
        cok_nxt       = 1'b1;
        whole_nxt     = '0;
        phase_nxt     = PH_START;
        cnt_nxt       = '0;
        fnz_nxt       = 1'b0;
        hmatch_nxt    = 1'b1;
        hmatch_cr_nxt = 1'b1;
        last_cr_nxt   = 1'b0;
      end else if (do_end) begin
        if (row_end) begin
          if (rows_r != 32'hffff_ffff) begin
            rows_nxt = rows_r + 32'd1;
          end
          col_nxt = COL_MAC;
        end else begin
          col_nxt = col_r + 4'd1;
        end
        qclosed_nxt   = 1'b0;
        pcr_nxt       = 1'b0;
        clen_nxt      = '0;
        cok_nxt       = 1'b1;
        whole_nxt     = '0;
        phase_nxt     = PH_START;
        cnt_nxt       = '0;
        fnz_nxt       = 1'b0;
        hmatch_nxt    = 1'b1;
        hmatch_cr_nxt = 1'b1;
        last_cr_nxt   = 1'b0;
      end else if (hstage_r == HS_DATA && inq_r && ch == CH_QUOTE) begin
        inq_nxt     = 1'b0;
        qclosed_nxt = 1'b1;
      end else if (hstage_r == HS_DATA && !inq_r && ch == CH_CR) begin
        pcr_nxt = 1'b1;
      end else if (hstage_r == HS_DATA && !inq_r && ch == CH_QUOTE && !qclosed_r) begin
        pcr_nxt = 1'b0;
        inq_nxt = 1'b1;
      end else if (do_app) begin
        if (hstage_r == HS_DATA && !inq_r) begin
          pcr_nxt = 1'b0;
          if (ch == CH_QUOTE) begin
            // Doubled quote: reopen and store one quote.
            inq_nxt     = 1'b1;
            qclosed_nxt = 1'b0;
          end
        end
        // Per-column content checks on the stored byte.
        if (hstage_r == HS_VER) begin
          if (clen_r < LW'(VER_LEN) &&
              ch != VER_TEXT[(VER_LEN - 1 - 32'(clen_r)) * 8 +: 8]) begin
            hmatch_nxt = 1'b0;
          end
        end else if (hstage_r == HS_COLS) begin
          hmatch_cr_nxt = hmatch_r;
          if (clen_r >= LW'(HDR_LEN) ||
              ch != HDR_TEXT[(HDR_LEN - 1 - 32'(clen_r)) * 8 +: 8]) begin
            hmatch_nxt = 1'b0;
          end
        end else if (col_r == COL_MAC) begin
          // Separator positions of the five colons.
          mac_sep = (clen_r == LW'(2)) || (clen_r == LW'(5)) || (clen_r == LW'(8)) ||
                    (clen_r == LW'(11)) || (clen_r == LW'(14));
          if (clen_r >= LW'(17)) begin
            cok_nxt = 1'b0;
          end else if (mac_sep) begin
            if (ch != CH_COLON) cok_nxt = 1'b0;
          end else if (!is_hex(ch)) begin
            cok_nxt = 1'b0;
          end
        end else if (col_r == COL_TIME) begin
          if ((clen_r == LW'(4) || clen_r == LW'(7)) && ch != CH_MINUS) cok_nxt = 1'b0;
          if (clen_r == LW'(10) && ch != CH_SPACE) cok_nxt = 1'b0;
        end else if (col_r == COL_LAT || col_r == COL_LON) begin
          if (cok_r) begin
            wmul = 14'(whole_r) * 14'd10 + 14'(d);
            if (phase_r == PH_START && ch == CH_MINUS) begin
              phase_nxt = PH_SIGN;
            end else if ((phase_r == PH_START || phase_r == PH_SIGN) && dig) begin
              phase_nxt = PH_WHOLE;
              cnt_nxt   = 4'd1;
              whole_nxt = 10'(d);
            end else if (phase_r == PH_WHOLE && dig) begin
              if (cnt_r >= 4'd3) begin
                cok_nxt = 1'b0;
              end else begin
                cnt_nxt   = cnt_r + 4'd1;
                whole_nxt = wmul[9:0];
              end
            end else if (phase_r == PH_WHOLE && ch == CH_DOT) begin
              phase_nxt = PH_DOT;
              cnt_nxt   = 4'd0;
            end else if (phase_r == PH_DOT && dig) begin
              phase_nxt = PH_FRAC;
              cnt_nxt   = 4'd1;
              fnz_nxt   = (d != 4'd0);
            end else if (phase_r == PH_FRAC && dig) begin
              if (cnt_r >= 4'd9) begin
                cok_nxt = 1'b0;
              end else begin
                cnt_nxt = cnt_r + 4'd1;
                if (d != 4'd0) fnz_nxt = 1'b1;
              end
            end else begin
              cok_nxt = 1'b0;
            end
          end
        end else if (col_r == COL_TYPE) begin
          if (clen_r >= LW'(4) ||
              ch != TYPE_TEXT[(3 - 32'(clen_r[1:0])) * 8 +: 8]) begin
            cok_nxt = 1'b0;
          end
        end
        last_cr_nxt = (ch == CH_CR);
        clen_nxt    = clen_r + 1'b1;
      end
    end

    // Result value.
    if (in_req_type == REQ_END) begin
      if (err_r || hstage_r != HS_DATA || inq_r) begin
        ook_nxt = 1'b0;
      end else if (feed && fail) begin
        ook_nxt = 1'b0;
      end else begin
        ook_nxt = (rows_nxt != 32'd0);
      end
    end else begin
      ook_nxt = !err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hstage_r    <= HS_VER;
      clen_r      <= '0;
      hmatch_r    <= 1'b1;
      hmatch_cr_r <= 1'b1;
      last_cr_r   <= 1'b0;
      inq_r       <= 1'b0;
      qclosed_r   <= 1'b0;
      pcr_r       <= 1'b0;
      col_r       <= COL_MAC;
      cok_r       <= 1'b1;
      whole_r     <= '0;
      phase_r     <= PH_START;
      cnt_r       <= '0;
      fnz_r       <= 1'b0;
      rows_r      <= '0;
      err_r       <= 1'b0;
      ovalid_r    <= 1'b0;
    end else begin
      hstage_r    <= hstage_nxt;
      clen_r      <= clen_nxt;
      hmatch_r    <= hmatch_nxt;
      hmatch_cr_r <= hmatch_cr_nxt;
      last_cr_r   <= last_cr_nxt;
      inq_r       <= inq_nxt;
      qclosed_r   <= qclosed_nxt;
      pcr_r       <= pcr_nxt;
      col_r       <= col_nxt;
      cok_r       <= cok_nxt;
      whole_r     <= whole_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      fnz_r       <= fnz_nxt;
      rows_r      <= rows_nxt;
      err_r       <= err_nxt;
      if (take) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // Result payload: loaded with each accepted item.
  always_ff @(posedge clk) begin
    if (take) begin
      ook_r   <= ook_nxt;
      orows_r <= rows_nxt;
    end
  end

endmodule
